### rtl/lbra_pkg.sv
// Shared types and constants for the lifetime buffer reuse allocator.
`default_nettype none
package lbra_pkg;

  localparam int NUM_BUFFERS     = 64;
  localparam int UNIT_INDEX_BITS = 16;

  localparam int IDX_W   = $clog2(NUM_BUFFERS);
  localparam int CNT_W   = $clog2(NUM_BUFFERS + 1);
  localparam int UNIT_W  = UNIT_INDEX_BITS;
  localparam int PORT_UNIT_W = 16;
  localparam int ID_W    = 6;
  localparam int TOTAL_W = 7;

  typedef enum logic {
    ACT_CLEAR = 1'b0,
    ACT_ALLOC = 1'b1
  } lbra_action_e;

  typedef struct packed {
    lbra_action_e      action;
    logic [UNIT_W-1:0] cur;
    logic [UNIT_W-1:0] last;
    logic              no_alias;
  } lbra_req_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TOTAL_W-1:0] total;
    logic               full;
  } lbra_res_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              we;
    logic [IDX_W-1:0]  wr_addr;
    logic [UNIT_W-1:0] wr_data;
  } lbra_mem_req_t;

endpackage
`default_nettype wire

### rtl/lbra_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none
module lbra_ram #(
  parameter int Depth = 64,
  parameter int Width = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/lbra_ctrl.sv
// Request sequencer: first-fit scan of the last-use table and table update.
`default_nettype none
module lbra_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   req_valid_i,
  input  wire lbra_pkg::lbra_req_t    req_i,
  output logic                        req_ready_o,
  output logic                        res_valid_o,
  output lbra_pkg::lbra_res_t         res_o,
  input  wire logic                   res_ready_i,
  output lbra_pkg::lbra_mem_req_t     mem_o,
  input  wire logic [lbra_pkg::UNIT_W-1:0] mem_rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  localparam logic [lbra_pkg::CNT_W-1:0] NumCnt = lbra_pkg::CNT_W'(lbra_pkg::NUM_BUFFERS);

  state_e                          state_q, state_d;
  logic [lbra_pkg::UNIT_W-1:0]     cur_q, cur_d;
  logic [lbra_pkg::UNIT_W-1:0]     last_q, last_d;
  logic                            strict_q, strict_d;
  logic [lbra_pkg::CNT_W-1:0]      count_q, count_d;
  logic [lbra_pkg::IDX_W-1:0]      rdidx_q, rdidx_d;
  lbra_pkg::lbra_res_t             res_q, res_d;

  logic                            hit;
  logic                            last_ent;
  logic [lbra_pkg::CNT_W-1:0]      count_inc;

  assign hit       = strict_q ? (mem_rdata_i < cur_q) : (mem_rdata_i <= cur_q);
  assign last_ent  = (lbra_pkg::CNT_W'(rdidx_q) + lbra_pkg::CNT_W'(1)) == count_q;
  assign count_inc = count_q + lbra_pkg::CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    last_d      = last_q;
    strict_d    = strict_q;
    count_d     = count_q;
    rdidx_d     = rdidx_q;
    res_d       = res_q;
    req_ready_o = 1'b0;
    mem_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cur_d    = req_i.cur;
          last_d   = req_i.last;
          strict_d = req_i.no_alias;
          if (req_i.action == lbra_pkg::ACT_CLEAR) begin
            count_d = '0;
            res_d   = '0;
            state_d = ST_DONE;
          end else if (count_q == '0) begin
            mem_o.we      = 1'b1;
            mem_o.wr_addr = '0;
            mem_o.wr_data = req_i.last;
            count_d       = lbra_pkg::CNT_W'(1);
            res_d.id      = '0;
            res_d.total   = lbra_pkg::TOTAL_W'(1);
            res_d.full    = 1'b0;
            state_d       = ST_DONE;
          end else begin
            mem_o.rd_en   = 1'b1;
            mem_o.rd_addr = '0;
            rdidx_d       = '0;
            state_d       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          mem_o.we      = 1'b1;
          mem_o.wr_addr = rdidx_q;
          mem_o.wr_data = last_q;
          res_d.id      = lbra_pkg::ID_W'(rdidx_q);
          res_d.total   = lbra_pkg::TOTAL_W'(count_q);
          res_d.full    = 1'b0;
          state_d       = ST_DONE;
        end else if (last_ent) begin
          if (count_q == NumCnt) begin
            res_d.id    = '0;
            res_d.total = lbra_pkg::TOTAL_W'(count_q);
            res_d.full  = 1'b1;
          end else begin
            mem_o.we      = 1'b1;
            mem_o.wr_addr = count_q[lbra_pkg::IDX_W-1:0];
            mem_o.wr_data = last_q;
            count_d       = count_inc;
            res_d.id      = lbra_pkg::ID_W'(count_q[lbra_pkg::IDX_W-1:0]);
            res_d.total   = lbra_pkg::TOTAL_W'(count_inc);
            res_d.full    = 1'b0;
          end
          state_d = ST_DONE;
        end else begin
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = rdidx_q + lbra_pkg::IDX_W'(1);
          rdidx_d       = rdidx_q + lbra_pkg::IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      cur_q    <= '0;
      last_q   <= '0;
      strict_q <= 1'b0;
      rdidx_q  <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cur_q    <= cur_d;
      last_q   <= last_d;
      strict_q <= strict_d;
      rdidx_q  <= rdidx_d;
      res_q    <= res_d;
    end
  end

  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule
`default_nettype wire

### rtl/lifetime_buffer_reuse_allocator.sv
// Lifetime buffer reuse allocator: top level with output register.
//
// Each word in is a clear or an allocate request; each gives one result word.
// The last-use table sits in a single-port-read RAM and an allocate against a
// non-empty table scans it from buffer 0 upward one entry per cycle, stopping
// at the first entry that fits or at the last one in use. The table needs no
// clearing pass after reset: only entries below the buffer count are ever
// read. A finished result waits in the output register while the next
// request is taken.
`default_nettype none
module lifetime_buffer_reuse_allocator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               action_i,
  input  wire logic [lbra_pkg::PORT_UNIT_W-1:0]   current_unit_i,
  input  wire logic [lbra_pkg::PORT_UNIT_W-1:0]   last_use_i,
  input  wire logic                               no_alias_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [lbra_pkg::ID_W-1:0]               buf_index_o,
  output logic [lbra_pkg::TOTAL_W-1:0]            buffer_total_o,
  output logic                                    table_full_o
);

  lbra_pkg::lbra_req_t         req;
  lbra_pkg::lbra_res_t         res;
  lbra_pkg::lbra_res_t         out_q;
  lbra_pkg::lbra_mem_req_t     mem_req;
  logic [lbra_pkg::UNIT_W-1:0] mem_rdata;
  logic                        res_valid;
  logic                        res_ready;
  logic                        out_valid_q;

  assign req.action   = lbra_pkg::lbra_action_e'(action_i);
  assign req.cur      = lbra_pkg::UNIT_W'(current_unit_i);
  assign req.last     = lbra_pkg::UNIT_W'(last_use_i);
  assign req.no_alias = no_alias_i;

  lbra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (req),
    .req_ready_o (in_ready_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  lbra_ram #(
    .Depth (lbra_pkg::NUM_BUFFERS),
    .Width (lbra_pkg::UNIT_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.wr_addr),
    .wdata_i (mem_req.wr_data),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign buf_index_o    = out_q.id;
  assign buffer_total_o = out_q.total;
  assign table_full_o   = out_q.full;

endmodule
`default_nettype wire

### rtl/lbra_checker.sv
// Port-level checks for the lifetime buffer reuse allocator, with bind.
`default_nettype none
module lbra_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic [lbra_pkg::ID_W-1:0]        buf_index_o,
  input wire logic [lbra_pkg::TOTAL_W-1:0]     buffer_total_o,
  input wire logic                             table_full_o
);

  localparam logic [lbra_pkg::TOTAL_W-1:0] FullTotal =
    lbra_pkg::TOTAL_W'(lbra_pkg::NUM_BUFFERS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(buf_index_o)
      && $stable(buffer_total_o) && $stable(table_full_o))
    else $error("result word changed while stalled");

  a_full_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> buf_index_o == '0 && buffer_total_o == FullTotal)
    else $error("full result with nonzero id or short count");

  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !table_full_o && buffer_total_o != '0
      |-> lbra_pkg::TOTAL_W'(buf_index_o) < buffer_total_o)
    else $error("buffer id beyond buffer count");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in progress");

endmodule

bind lifetime_buffer_reuse_allocator lbra_checker u_lbra_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .buf_index_o    (buf_index_o),
  .buffer_total_o (buffer_total_o),
  .table_full_o   (table_full_o)
);
`default_nettype wire

### verif/tb_lifetime_buffer_reuse_allocator.sv
// Testbench for lifetime_buffer_reuse_allocator: predicts buffer picks and checks results.
`timescale 1ns / 100ps
module tb_lifetime_buffer_reuse_allocator;

  logic                             clk_i          = 1'b0;
  logic                             rst_ni         = 1'b0;
  logic                             in_valid_i     = 1'b0;
  logic                             in_ready_o;
  logic                             action_i       = 1'b0;
  logic [lbra_pkg::PORT_UNIT_W-1:0] current_unit_i = '0;
  logic [lbra_pkg::PORT_UNIT_W-1:0] last_use_i     = '0;
  logic                             no_alias_i     = 1'b0;
  logic                             out_valid_o;
  logic                             out_ready_i    = 1'b0;
  logic [lbra_pkg::ID_W-1:0]        buf_index_o;
  logic [lbra_pkg::TOTAL_W-1:0]     buffer_total_o;
  logic                             table_full_o;

  logic [lbra_pkg::UNIT_W-1:0] live_last_use [lbra_pkg::NUM_BUFFERS];
  int                          live_count    = 0;
  lbra_pkg::lbra_res_t         pending_results[$];
  int                          mismatch_count = 0;
  int                          words_sent     = 0;
  int                          send_idle_pct  = 15;
  int                          recv_idle_pct  = 65;

  lifetime_buffer_reuse_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .current_unit_i (current_unit_i),
    .last_use_i     (last_use_i),
    .no_alias_i     (no_alias_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .buf_index_o    (buf_index_o),
    .buffer_total_o (buffer_total_o),
    .table_full_o   (table_full_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    #10_000_000;
    $display("lifetime_buffer_reuse_allocator regression: fail");
    $finish;
  end

  function automatic lbra_pkg::lbra_res_t predict_alloc(
      input lbra_pkg::lbra_action_e act,
      input logic [lbra_pkg::PORT_UNIT_W-1:0] cur_in,
      input logic [lbra_pkg::PORT_UNIT_W-1:0] last_in,
      input logic strict);
    lbra_pkg::lbra_res_t         res;
    logic [lbra_pkg::UNIT_W-1:0] cur;
    logic [lbra_pkg::UNIT_W-1:0] last;
    int                          pick;
    res  = '0;
    cur  = cur_in[lbra_pkg::UNIT_W-1:0];
    last = last_in[lbra_pkg::UNIT_W-1:0];
    pick = -1;
    if (act == lbra_pkg::ACT_CLEAR) begin
      live_count = 0;
      return res;
    end
    for (int i = 0; i < live_count; i++) begin
      if (pick < 0 && (strict ? (live_last_use[i] < cur) : (live_last_use[i] <= cur)))
        pick = i;
    end
    if (pick < 0 && live_count < lbra_pkg::NUM_BUFFERS) begin
      pick = live_count;
      live_count++;
    end
    if (pick >= 0) begin
      live_last_use[pick] = last;
      res.id = pick[lbra_pkg::ID_W-1:0];
    end else begin
      res.full = 1'b1;
    end
    res.total = live_count[lbra_pkg::TOTAL_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_word(input lbra_pkg::lbra_action_e act, input int cur, input int last,
                           input logic na);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    current_unit_i <= cur[lbra_pkg::PORT_UNIT_W-1:0];
    last_use_i     <= last[lbra_pkg::PORT_UNIT_W-1:0];
    no_alias_i     <= na;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    pending_results.insert(pending_results.size(),
                           predict_alloc(act, cur[lbra_pkg::PORT_UNIT_W-1:0],
                                         last[lbra_pkg::PORT_UNIT_W-1:0], na));
    words_sent++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    lbra_pkg::lbra_res_t want;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, buf_index", buf_index_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (buf_index_o !== want.id)
          report_mismatch("buf_index", buf_index_o, want.id);
        if (buffer_total_o !== want.total)
          report_mismatch("buffer_total", buffer_total_o, want.total);
        if (table_full_o !== want.full)
          report_mismatch("table_full", table_full_o, want.full);
      end
    end
  end

  task automatic test_directed();
    send_word(lbra_pkg::ACT_CLEAR, 0, 0, 1'b0);
    send_word(lbra_pkg::ACT_ALLOC, 0, 0, 1'b0);
    send_word(lbra_pkg::ACT_ALLOC, 0, 0, 1'b0);
    send_word(lbra_pkg::ACT_ALLOC, 0, 'hFFFF, 1'b1);
    send_word(lbra_pkg::ACT_ALLOC, 'hFFFF, 'hFFFF, 1'b1);
    send_word(lbra_pkg::ACT_ALLOC, 'hFFFF, 0, 1'b1);
    send_word(lbra_pkg::ACT_ALLOC, 'hFFFF, 'h1234, 1'b0);
    send_word(lbra_pkg::ACT_ALLOC, 1, 'hAAAA, 1'b1);
    send_word(lbra_pkg::ACT_ALLOC, 'h5555, 'h5555, 1'b1);
    send_word(lbra_pkg::ACT_ALLOC, 'h5555, 'hAAAA, 1'b0);
    send_word(lbra_pkg::ACT_ALLOC, 'hAAAA, 'h5555, 1'b1);
    send_word(lbra_pkg::ACT_ALLOC, 'hAAAA, 'hAAAA, 1'b0);
    send_word(lbra_pkg::ACT_CLEAR, 'hFFFF, 'hFFFF, 1'b1);
    send_word(lbra_pkg::ACT_CLEAR, 0, 0, 1'b0);
    send_word(lbra_pkg::ACT_ALLOC, 'h8000, 'h7FFF, 1'b1);
    send_word(lbra_pkg::ACT_ALLOC, 'h7FFF, 'h8000, 1'b1);
    send_word(lbra_pkg::ACT_ALLOC, 'h8000, 'h8000, 1'b1);
    send_word(lbra_pkg::ACT_ALLOC, 'h8000, 'h8001, 1'b0);
    send_word(lbra_pkg::ACT_CLEAR, 'h1234, 'h4321, 1'b0);
  endtask

  // Long-lived outputs pile up until no buffer is left.
  task automatic test_table_full();
    int cur;
    cur = $urandom_range(60000, 0);
    send_word(lbra_pkg::ACT_CLEAR, 0, 0, 1'b0);
    for (int i = 0; i < lbra_pkg::NUM_BUFFERS + 6; i++)
      send_word(lbra_pkg::ACT_ALLOC, cur, cur + $urandom_range(65535 - cur, 1),
                1'($urandom_range(1, 0)));
    send_word(lbra_pkg::ACT_ALLOC, 'hFFFF, $urandom_range(65535, 0), 1'b0);
  endtask

  task automatic test_graph_reuse(input int n_units);
    int cur;
    int last;
    int span;
    case ($urandom_range(2, 0))
      0:       span = 4;
      1:       span = 64;
      default: span = 2000;
    endcase
    cur = $urandom_range(65000, 0);
    send_word(lbra_pkg::ACT_CLEAR, $urandom_range(65535, 0), $urandom_range(65535, 0),
              1'($urandom_range(1, 0)));
    for (int i = 0; i < n_units; i++) begin
      cur = cur + $urandom_range(2, 0);
      if (cur > 65535) cur = 65535;
      if ($urandom_range(9, 0) == 0) last = $urandom_range(cur, 0);
      else last = cur + $urandom_range(span, 0);
      if (last > 65535) last = 65535;
      send_word(lbra_pkg::ACT_ALLOC, cur, last, $urandom_range(3, 0) == 0);
    end
  endtask

  task automatic test_random_noise(input int n_words);
    for (int i = 0; i < n_words; i++)
      send_word(($urandom_range(9, 0) == 0) ? lbra_pkg::ACT_CLEAR : lbra_pkg::ACT_ALLOC,
                $urandom_range(65535, 0), $urandom_range(65535, 0),
                1'($urandom_range(1, 0)));
  endtask

  initial begin
    int pick;
    int phase_start;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < 375) begin
        pick = $urandom_range(9, 0);
        if (pick == 0) test_table_full();
        else if (pick < 3) test_random_noise(10);
        else test_graph_reuse($urandom_range(40, 5));
      end
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("lifetime_buffer_reuse_allocator regression: pass");
    end else begin
      $display("lifetime_buffer_reuse_allocator regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/lbra_pkg.sv
rtl/lbra_ram.sv
rtl/lbra_ctrl.sv
rtl/lifetime_buffer_reuse_allocator.sv
rtl/lbra_checker.sv
verif/tb_lifetime_buffer_reuse_allocator.sv
